>>> hw/rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and stage-constant functions for the TEA pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned ROUNDS      = 16;
  localparam int unsigned STAGES      = 2 * ROUNDS;   // one half round per stage
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_0 = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_1 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_2 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_3 = 3'd3;

  // operation codes
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] z;
  } tea_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] k0;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k3;
  } tea_key_t;

  // running sum seen by a stage when encrypting: delta * (round + 1)
  function automatic logic [WORD_W-1:0] enc_sum(int unsigned stage);
    logic [63:0] p;
    p = 64'(DELTA) * 64'((stage >> 1) + 1);
    return p[WORD_W-1:0];
  endfunction

  // running sum seen by a stage when decrypting: delta * (ROUNDS - round)
  function automatic logic [WORD_W-1:0] dec_sum(int unsigned stage);
    logic [63:0] p;
    p = 64'(DELTA) * 64'(ROUNDS - (stage >> 1));
    return p[WORD_W-1:0];
  endfunction

  // encryption updates y in the first half of a round, z in the second
  function automatic logic y_first_enc(int unsigned stage);
    return ((stage & 1) == 0) ? 1'b1 : 1'b0;
  endfunction

endpackage

>>> hw/rtl/tea_key_regs.sv
// ----------------------------------------------------------------------------
// tea_key_regs
// Holds the four 32-bit key words written through the configuration port.
// ----------------------------------------------------------------------------
module tea_key_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [tea_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]          cfg_data,
  output tea_pkg::tea_key_t                   key
);
  import tea_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_KEY_0: key.k0 <= cfg_data;
        REG_KEY_1: key.k1 <= cfg_data;
        REG_KEY_2: key.k2 <= cfg_data;
        REG_KEY_3: key.k3 <= cfg_data;
        default: ;  // unmapped index: ignored
      endcase
    end
  end

endmodule

>>> hw/rtl/tea_half_round.sv
// ----------------------------------------------------------------------------
// tea_half_round
// One pipeline stage: a single half-round update, add or subtract by opcode.
// ----------------------------------------------------------------------------
module tea_half_round (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        enable,
  input  tea_pkg::tea_key_t           key,
  input  logic [tea_pkg::WORD_W-1:0]  sum_enc,
  input  logic [tea_pkg::WORD_W-1:0]  sum_dec,
  input  logic                        y_first,
  input  logic                        prev_valid,
  input  tea_pkg::tea_word_t          prev_word,
  output logic                        valid,
  output tea_pkg::tea_word_t          word
);
  import tea_pkg::*;

  logic              upd_y;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] kx;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] s;
  logic [WORD_W-1:0] mix;
  logic [WORD_W-1:0] dst_new;
  tea_word_t         word_next;

  always_comb begin
    // decryption runs the halves in the opposite order
    upd_y   = y_first ^ (prev_word.op == OP_DECRYPT);
    src     = upd_y ? prev_word.z : prev_word.y;
    dst     = upd_y ? prev_word.y : prev_word.z;
    kx      = upd_y ? key.k0 : key.k2;
    ka      = upd_y ? key.k1 : key.k3;
    s       = (prev_word.op == OP_DECRYPT) ? sum_dec : sum_enc;
    mix     = (src << 4) + (kx ^ src) + (s ^ (src >> 5)) + ka;
    dst_new = (prev_word.op == OP_DECRYPT) ? dst - mix : dst + mix;

    word_next    = prev_word;
    if (upd_y) begin
      word_next.y = dst_new;
    end else begin
      word_next.z = dst_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (enable) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (enable) begin
      word <= word_next;
    end
  end

endmodule

>>> hw/rtl/tea_block_cipher_16_rounds.sv
// ----------------------------------------------------------------------------
// tea_block_cipher_16_rounds
// TEA block cipher, 16 rounds, fully unrolled into a half-round pipeline.
// Throughput: one word per cycle while the result side is not stalling; each
// of the 32 half-round stages holds one.
// Reset: synchronous rst clears all stage valid bits and the key words to 0.
// ----------------------------------------------------------------------------
module tea_block_cipher_16_rounds (
  input  logic                                clk,
  input  logic                                rst,
  // configuration: key words 0..3, write only
  input  logic                                cfg_write,
  input  logic [tea_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tea_pkg::WORD_W-1:0]          cfg_data,
  // block words in
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                opcode,
  input  logic [tea_pkg::WORD_W-1:0]          word_y,
  input  logic [tea_pkg::WORD_W-1:0]          word_z,
  // block words out
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [tea_pkg::WORD_W-1:0]          result_y,
  output logic [tea_pkg::WORD_W-1:0]          result_z
);
  import tea_pkg::*;

  // Stage 0 is the input port; stage STAGES is the last register, which
  // doubles as the output register. All stages move together: the pipe
  // advances whenever the output register is empty or being taken, so a
  // stall freezes every word in place and nothing is lost or repeated.

  tea_key_t  key;
  logic      advance;
  logic      stage_valid [STAGES+1];
  tea_word_t stage_word  [STAGES+1];

  tea_key_regs u_key_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign advance    = !stage_valid[STAGES] || !result_stall;
  assign item_stall = !advance;

  assign stage_valid[0]   = item_valid;
  assign stage_word[0].op = opcode;
  assign stage_word[0].y  = word_y;
  assign stage_word[0].z  = word_z;

  // Each stage gets its own round sums as elaboration-time constants.
  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    tea_half_round u_half (
      .clk        (clk),
      .rst        (rst),
      .enable     (advance),
      .key        (key),
      .sum_enc    (enc_sum(g)),
      .sum_dec    (dec_sum(g)),
      .y_first    (y_first_enc(g)),
      .prev_valid (stage_valid[g]),
      .prev_word  (stage_word[g]),
      .valid      (stage_valid[g+1]),
      .word       (stage_word[g+1])
    );
  end

  assign result_valid = stage_valid[STAGES];
  assign result_y     = stage_word[STAGES].y;
  assign result_z     = stage_word[STAGES].z;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 16-round TEA pipeline. Block words are pushed in
// under random gaps and the result side stalls at random (with long hold-offs
// to back the pipe up). Every accepted block is run through a local 16-round
// TEA model with the current key, and results are compared in order. Keys are
// rewritten between phases once the pipe has drained.
// ----------------------------------------------------------------------------
module tb;
  import tea_pkg::*;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t y;
    word_t z;
  } block_pair_t;

  // one row of the directed table; 'undo' feeds the previous row's result
  // back in, 'typed' means the expected words below are used as they stand
  typedef struct packed {
    logic  op;
    logic  undo;
    logic  typed;
    word_t y;
    word_t z;
    word_t ey;
    word_t ez;
  } dir_row_t;

  localparam int DIR_ROWS         = 16;
  localparam int PHASES           = 6;
  localparam int RANDOM_PER_PHASE = 306;
  localparam int CALM_PHASE       = 3;       // no random idling on either side; hold-offs still occur
  localparam int IDLE_PCT         = 21;
  localparam int HOLD_CYCLES      = 160;     // long result hold-off, > pipe depth
  localparam int FIRST_HOLD_AT    = 300;
  localparam int HOLD_SPACING     = 900;
  localparam int CYCLE_LIMIT      = 400000;

  // writes above the last key index must be ignored by the block
  localparam logic [CFG_INDEX_W-1:0] REG_NONE_LO = 3'd4;

  logic                   clk          = 1'b0;
  logic                   rst          = 1'b1;
  logic                   cfg_write    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index    = REG_KEY_0;
  word_t                  cfg_data     = '0;
  logic                   item_valid   = 1'b0;
  logic                   item_stall;
  logic                   opcode       = OP_ENCRYPT;
  word_t                  word_y       = '0;
  word_t                  word_z       = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  word_t                  result_y;
  word_t                  result_z;

  tea_block_cipher_16_rounds dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .word_y       (word_y),
    .word_z       (word_z),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_y     (result_y),
    .result_z     (result_z)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the key, kept in step with every register write
  tea_key_t    key_now = '0;
  block_pair_t awaited_blocks [$];
  block_pair_t head_block;
  int          fail_count   = 0;
  int          results_seen = 0;
  int          cycle_count  = 0;
  int          hold_left    = 0;
  int          next_hold_at = FIRST_HOLD_AT;
  logic        calm         = 1'b0;

  // ---------------------------------------------------------------------------
  // Local TEA model
  // ---------------------------------------------------------------------------

  // one half-round term: (w<<4) + (kx^w) + (s^(w>>5)) + ka, all mod 2^32
  function automatic word_t half_mix(word_t w, word_t kx, word_t ka, word_t s);
    return (w << 4) + (kx ^ w) + (s ^ (w >> 5)) + ka;
  endfunction

  function automatic block_pair_t tea_transform(logic op, word_t y, word_t z);
    word_t       sum;
    block_pair_t res;
    sum = '0;
    if (op == OP_ENCRYPT) begin
      for (int r = 0; r < ROUNDS; r++) begin
        sum += DELTA;
        y   += half_mix(z, key_now.k0, key_now.k1, sum);
        z   += half_mix(y, key_now.k2, key_now.k3, sum);
      end
    end else begin
      // decryption starts from delta * ROUNDS and walks the rounds backwards
      for (int r = 0; r < ROUNDS; r++) sum += DELTA;
      for (int r = 0; r < ROUNDS; r++) begin
        z   -= half_mix(y, key_now.k2, key_now.k3, sum);
        y   -= half_mix(z, key_now.k0, key_now.k1, sum);
        sum -= DELTA;
      end
    end
    res.y = y;
    res.z = z;
    return res;
  endfunction

  // mostly uniform, with zero, all ones, one-hot and one-cold words mixed in
  function automatic word_t pick_word();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(WORD_W - 1);
      3:       return ~(word_t'(1) << $urandom_range(WORD_W - 1));
      default: return word_t'($urandom());
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // register write at the next rising edge; the key copy follows at once since
  // writes only happen with the pipe empty
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input word_t data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_KEY_0: key_now.k0 = data;
      REG_KEY_1: key_now.k1 = data;
      REG_KEY_2: key_now.k2 = data;
      REG_KEY_3: key_now.k3 = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // offer one block word, hold it while stalled, log the expected result once
  // the block takes it
  task automatic offer_block(input logic op, input word_t y, input word_t z,
                             input block_pair_t want);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    word_y     <= y;
    word_z     <= z;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    awaited_blocks.push_back(want);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus occasional long hold-offs. A hold-off
  // lasts well beyond the 32-stage depth, so the pipe fills and item_stall
  // has to rise while the sender keeps offering.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left != 0) begin
      result_stall <= 1'b1;
      hold_left    <= hold_left - 1;
    end else if (results_seen >= next_hold_at) begin
      result_stall <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end else begin
      result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // in-order check of every accepted result word
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (awaited_blocks.size() == 0) begin
        $error("result word with nothing awaited: result_y %h result_z %h",
               result_y, result_z);
        fail_count++;
      end else begin
        head_block = awaited_blocks.pop_front();
        if (result_y !== head_block.y) begin
          $error("result_y: expected %h, got %h", head_block.y, result_y);
          fail_count++;
        end
        if (result_z !== head_block.z) begin
          $error("result_z: expected %h, got %h", head_block.z, result_z);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  dir_row_t dir_rows [0:DIR_ROWS-1];

  initial begin
    dir_row_t                row;
    block_pair_t             pred;
    block_pair_t             prev_out;
    block_pair_t             last_cipher;
    block_pair_t             typed_out;
    tea_key_t                new_key;
    logic [CFG_INDEX_W-1:0]  spare_idx;
    logic                    have_cipher;
    logic                    op;
    word_t                   y;
    word_t                   z;

    // Runs with the key at its reset value of zero. A decrypt fed with the
    // previous encrypt's output (or the other way round) must give back the
    // original words, so those rows carry their answer typed in.
    dir_rows = '{
      '{OP_ENCRYPT, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0},
      '{OP_DECRYPT, 1'b1, 1'b1, 32'h0,         32'h0,
        32'h0000_0000, 32'h0000_0000},
      '{OP_ENCRYPT, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
      '{OP_DECRYPT, 1'b1, 1'b1, 32'h0,         32'h0,
        32'hFFFF_FFFF, 32'hFFFF_FFFF},
      '{OP_DECRYPT, 1'b0, 1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0},
      '{OP_DECRYPT, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0},
      '{OP_ENCRYPT, 1'b0, 1'b0, 32'h8000_0000, 32'h0000_0001, 32'h0, 32'h0},
      '{OP_DECRYPT, 1'b1, 1'b1, 32'h0,         32'h0,
        32'h8000_0000, 32'h0000_0001},
      '{OP_ENCRYPT, 1'b0, 1'b0, 32'h0000_0001, 32'h8000_0000, 32'h0, 32'h0},
      '{OP_ENCRYPT, 1'b0, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 32'h0},
      '{OP_DECRYPT, 1'b1, 1'b1, 32'h0,         32'h0,
        32'hAAAA_AAAA, 32'h5555_5555},
      '{OP_DECRYPT, 1'b0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0, 32'h0},
      '{OP_ENCRYPT, 1'b0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 32'h0},
      '{OP_ENCRYPT, 1'b0, 1'b0, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0},
      '{OP_DECRYPT, 1'b0, 1'b0, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'h0},
      '{OP_ENCRYPT, 1'b1, 1'b1, 32'h0,         32'h0,
        32'h1234_5678, 32'h9ABC_DEF0}
    };
    prev_out    = '0;
    last_cipher = '0;
    have_cipher = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      row      = dir_rows[i];
      y        = row.undo ? prev_out.y : row.y;
      z        = row.undo ? prev_out.z : row.z;
      pred     = tea_transform(row.op, y, z);
      prev_out = pred;
      if (row.typed) begin
        typed_out.y = row.ey;
        typed_out.z = row.ez;
        offer_block(row.op, y, z, typed_out);
      end else begin
        offer_block(row.op, y, z, pred);
      end
    end

    // random phases, each with its own key
    for (int phase = 0; phase < PHASES; phase++) begin
      // stop offering first, then let the pipe drain before the key writes
      @(negedge clk);
      item_valid <= 1'b0;
      while (awaited_blocks.size() != 0) @(posedge clk);
      calm = (phase == CALM_PHASE);

      case (phase)
        0: new_key = '1;
        1: new_key = '0;
        2: begin
          new_key.k0 = 32'hAAAA_AAAA;
          new_key.k1 = 32'h5555_5555;
          new_key.k2 = 32'h5555_5555;
          new_key.k3 = 32'hAAAA_AAAA;
        end
        default: begin
          new_key.k0 = pick_word();
          new_key.k1 = pick_word();
          new_key.k2 = pick_word();
          new_key.k3 = pick_word();
        end
      endcase
      write_reg(REG_KEY_3, new_key.k3);
      write_reg(REG_KEY_1, new_key.k1);
      write_reg(REG_KEY_0, new_key.k0);
      write_reg(REG_KEY_2, new_key.k2);
      // out-of-range index with junk data: must leave the key untouched
      spare_idx = REG_NONE_LO + {1'b0, phase[1:0]};
      write_reg(spare_idx, word_t'($urandom()));
      have_cipher = 1'b0;

      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        op = 1'($urandom_range(1));
        y  = pick_word();
        z  = pick_word();
        // now and then decrypt a block just encrypted under this key
        if (op == OP_DECRYPT && have_cipher && $urandom_range(3) == 0) begin
          y = last_cipher.y;
          z = last_cipher.z;
        end
        pred = tea_transform(op, y, z);
        if (op == OP_ENCRYPT) begin
          last_cipher = pred;
          have_cipher = 1'b1;
        end
        offer_block(op, y, z, pred);
      end
    end

    @(negedge clk);
    item_valid <= 1'b0;
    calm = 1'b0;

    // drain, then give stray words a chance to show up
    while (awaited_blocks.size() != 0) @(posedge clk);
    repeat (2 * STAGES) @(posedge clk);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
